/* rtl/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants for the handheld console bus decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

	localparam int HRAM_DEPTH = 127;
	localparam int HRAM_AW    = $clog2(HRAM_DEPTH);
	localparam int CFG_IDX_W  = 3;

	localparam logic [15:0] VRAM_BASE   = 16'h8000;
	localparam logic [15:0] WRAM_BASE   = 16'hC000;
	localparam logic [15:0] ECHO_BASE   = 16'hE000;
	localparam logic [8:0]  SPRITE_END  = 9'd160;
	localparam logic [8:0]  HRAM_FIRST  = 9'h180;
	localparam logic [8:0]  IE_IDX      = 9'h1FF;
	localparam logic [8:0]  REG_FIRST   = 9'h100;
	localparam logic [8:0]  BOOT_OFF    = 9'h150;
	localparam logic [8:0]  DMA_IDX     = 9'h146;
	localparam logic [8:0]  LY_IDX      = 9'h144;
	localparam logic [8:0]  JOYP_IDX    = 9'h100;
	localparam logic [7:0]  OPEN_BUS    = 8'hFF;

	typedef enum logic [3:0] {
		T_NONE   = 4'd0,
		T_BOOT   = 4'd1,
		T_CART   = 4'd2,
		T_VRAM   = 4'd3,
		T_WRAM   = 4'd4,
		T_SPRITE = 4'd5,
		T_HRAM   = 4'd6,
		T_CPUREG = 4'd7,
		T_VIDREG = 4'd8,
		T_JOYPAD = 4'd9,
		T_DMA    = 4'd10
	} target_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOOT  = 3'd0,
		CFG_CART  = 3'd1,
		CFG_VRAM  = 3'd2,
		CFG_WRAM  = 3'd3,
		CFG_TIMER = 3'd4,
		CFG_VIDEO = 3'd5,
		CFG_JOYP  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic boot_overlay_on;
		logic cartridge_present;
		logic video_ram_present;
		logic work_ram_present;
		logic timer_unit_present;
		logic video_unit_present;
		logic joypad_present;
	} cfg_t;

	typedef struct packed {
		target_t             target;
		logic [15:0]         target_offset;
		logic                is_write;
		logic [7:0]          forward_data;
		logic [7:0]          local_read_data;
		logic                local_read_valid;
		logic                hram_rd;
		logic                hram_we;
		logic [HRAM_AW-1:0]  hram_idx;
		logic                overlay_clear;
	} dec_t;

endpackage

`default_nettype wire

/* rtl/hbd_if.sv */
// ----------------------------------------------------------------------------
// hbd_if
// Word channels of the bus decoder: access, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbd_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] bus_address;
	logic [7:0]  bus_write_data;
	modport source (output valid, opcode, bus_address, bus_write_data, input ready);
	modport sink   (input valid, opcode, bus_address, bus_write_data, output ready);
endinterface

interface hbd_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  target;
	logic [15:0] target_offset;
	logic        is_write;
	logic [7:0]  forward_data;
	logic [7:0]  local_read_data;
	logic        local_read_valid;
	modport source (output valid, target, target_offset, is_write, forward_data,
		local_read_data, local_read_valid, input ready);
	modport sink   (input valid, target, target_offset, is_write, forward_data,
		local_read_data, local_read_valid, output ready);
endinterface

interface hbd_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [hbd_pkg::CFG_IDX_W-1:0] index;
	logic                         data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/hbd_cfg.sv */
// ----------------------------------------------------------------------------
// hbd_cfg
// Unit presence registers and the boot overlay flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_cfg (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hbd_cfg_if.sink      cfg,
	input  wire logic    overlay_clear,
	output hbd_pkg::cfg_t cfg_state
);

	hbd_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_state = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			if (overlay_clear)
				cfg_q.boot_overlay_on <= 1'b0;
			if (cfg.valid) begin
				case (cfg.index)
					hbd_pkg::CFG_BOOT:  cfg_q.boot_overlay_on    <= cfg.data;
					hbd_pkg::CFG_CART:  cfg_q.cartridge_present  <= cfg.data;
					hbd_pkg::CFG_VRAM:  cfg_q.video_ram_present  <= cfg.data;
					hbd_pkg::CFG_WRAM:  cfg_q.work_ram_present   <= cfg.data;
					hbd_pkg::CFG_TIMER: cfg_q.timer_unit_present <= cfg.data;
					hbd_pkg::CFG_VIDEO: cfg_q.video_unit_present <= cfg.data;
					hbd_pkg::CFG_JOYP:  cfg_q.joypad_present     <= cfg.data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/hbd_decode.sv */
// ----------------------------------------------------------------------------
// hbd_decode
// Address map decode of one bus access to target, offset and local answer.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_decode (
	input  wire logic        opcode,
	input  wire logic [15:0] bus_address,
	input  wire logic [7:0]  bus_write_data,
	input  hbd_pkg::cfg_t    cfg_state,
	output hbd_pkg::dec_t    dec
);

	logic [3:0]  page;
	logic [8:0]  idx;
	logic        wr;

	assign page = bus_address[15:12];
	assign idx  = bus_address[8:0];
	assign wr   = opcode;

	always_comb begin
		dec = '0;
		dec.target = hbd_pkg::T_NONE;
		if (page == 4'h0 && cfg_state.boot_overlay_on) begin
			dec.target_offset = bus_address;
			if (bus_address[15:8] == 8'h00)
				dec.target = hbd_pkg::T_BOOT;
			else if (cfg_state.cartridge_present)
				dec.target = hbd_pkg::T_CART;
		end else if (page inside {[4'h0:4'h7], 4'hA, 4'hB}) begin
			dec.target_offset = bus_address;
			if (cfg_state.cartridge_present)
				dec.target = hbd_pkg::T_CART;
		end else if (page inside {4'h8, 4'h9}) begin
			dec.target_offset = bus_address - hbd_pkg::VRAM_BASE;
			if (cfg_state.video_ram_present)
				dec.target = hbd_pkg::T_VRAM;
		end else if (page inside {4'hC, 4'hD}) begin
			dec.target_offset = bus_address - hbd_pkg::WRAM_BASE;
			if (cfg_state.work_ram_present)
				dec.target = hbd_pkg::T_WRAM;
		end else if (bus_address[15:9] != 7'h7F) begin
			dec.target_offset = bus_address - hbd_pkg::ECHO_BASE;
			if (cfg_state.work_ram_present)
				dec.target = hbd_pkg::T_WRAM;
		end else begin
			dec.overlay_clear = wr && (idx == hbd_pkg::BOOT_OFF);
			if (idx < hbd_pkg::SPRITE_END) begin
				dec.target_offset = {7'd0, idx};
				if (cfg_state.video_unit_present)
					dec.target = hbd_pkg::T_SPRITE;
			end else if (idx >= hbd_pkg::HRAM_FIRST && idx != hbd_pkg::IE_IDX) begin
				dec.target_offset = {7'd0, idx - hbd_pkg::HRAM_FIRST};
				dec.target = hbd_pkg::T_HRAM;
			end else if (idx >= hbd_pkg::REG_FIRST) begin
				dec.target_offset = {8'd0, idx[7:0]};
				if (idx == hbd_pkg::JOYP_IDX) begin
					if (cfg_state.joypad_present)
						dec.target = hbd_pkg::T_JOYPAD;
				end else if (idx inside {[9'h104:9'h107], 9'h10F, 9'h1FF}) begin
					if (cfg_state.timer_unit_present)
						dec.target = hbd_pkg::T_CPUREG;
				end else if (idx == hbd_pkg::DMA_IDX) begin
					if (wr && cfg_state.timer_unit_present)
						dec.target = hbd_pkg::T_DMA;
				end else if (idx inside {[9'h140:9'h143], [9'h147:9'h149]}) begin
					if (cfg_state.video_unit_present)
						dec.target = hbd_pkg::T_VIDREG;
				end else if (idx == hbd_pkg::LY_IDX) begin
					if (!wr && cfg_state.video_unit_present)
						dec.target = hbd_pkg::T_VIDREG;
				end
			end
		end

		if (dec.target == hbd_pkg::T_NONE) begin
			dec.target_offset = '0;
			if (!wr) begin
				dec.local_read_data  = hbd_pkg::OPEN_BUS;
				dec.local_read_valid = 1'b1;
			end
		end else if (dec.target == hbd_pkg::T_HRAM) begin
			dec.hram_idx = dec.target_offset[hbd_pkg::HRAM_AW-1:0];
			dec.hram_we  = wr;
			dec.hram_rd  = !wr;
			dec.local_read_valid = !wr;
		end

		dec.is_write     = wr && (dec.target != hbd_pkg::T_NONE);
		dec.forward_data = dec.is_write ? bus_write_data : 8'h00;
	end

endmodule

`default_nettype wire

/* rtl/hbd_hram.sv */
// ----------------------------------------------------------------------------
// hbd_hram
// High RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_hram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic                        re,
	input  wire logic [hbd_pkg::HRAM_AW-1:0] idx,
	input  wire logic [7:0]                  wdata,
	output logic      [7:0]                  rdata
);

	logic [7:0] mem [hbd_pkg::HRAM_DEPTH];
	logic [7:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[idx] <= wdata;
		if (re)
			rdata_q <= mem[idx];
	end

endmodule

`default_nettype wire

/* rtl/handheld_console_bus_decoder.sv */
// ----------------------------------------------------------------------------
// handheld_console_bus_decoder
// Pipeline: an accepted access word is registered in stage s1, then in stage s2, which drives the output.
// Throughput: one access per cycle while the result side is ready; the high RAM port takes one access a cycle.
// Reset: clears pipeline valids, presence bits and the boot overlay flag.
// High RAM is not cleared; no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_console_bus_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	hbd_req_if.sink   req,
	hbd_rsp_if.source rsp,
	hbd_cfg_if.sink   cfg
);

	hbd_pkg::cfg_t cfg_state;
	hbd_pkg::dec_t dec;
	hbd_pkg::dec_t dec_s1;
	logic          valid_s1;
	logic          valid_s2;
	logic          adv_s1;
	logic          acc;
	logic [7:0]    hram_rdata;
	logic [7:0]    rdata_res;

	logic [3:0]    target_s2;
	logic [15:0]   offset_s2;
	logic          is_write_s2;
	logic [7:0]    fwd_s2;
	logic [7:0]    rdata_s2;
	logic          rvalid_s2;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign acc       = req.valid && req.ready;

	hbd_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.overlay_clear (acc && dec.overlay_clear),
		.cfg_state     (cfg_state)
	);

	hbd_decode u_decode (
		.opcode         (req.opcode),
		.bus_address    (req.bus_address),
		.bus_write_data (req.bus_write_data),
		.cfg_state      (cfg_state),
		.dec            (dec)
	);

	hbd_hram u_hram (
		.clk   (clk),
		.we    (acc && dec.hram_we),
		.re    (acc && dec.hram_rd),
		.idx   (dec.hram_idx),
		.wdata (req.bus_write_data),
		.rdata (hram_rdata)
	);

	assign rdata_res = dec_s1.hram_rd ? hram_rdata : dec_s1.local_read_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			dec_s1 <= dec;
		if (adv_s1) begin
			target_s2   <= dec_s1.target;
			offset_s2   <= dec_s1.target_offset;
			is_write_s2 <= dec_s1.is_write;
			fwd_s2      <= dec_s1.forward_data;
			rdata_s2    <= rdata_res;
			rvalid_s2   <= dec_s1.local_read_valid;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.target           = target_s2;
	assign rsp.target_offset    = offset_s2;
	assign rsp.is_write         = is_write_s2;
	assign rsp.forward_data     = fwd_s2;
	assign rsp.local_read_data  = rdata_s2;
	assign rsp.local_read_valid = rvalid_s2;

endmodule

`default_nettype wire
